### hdl/sdsh_pkg.sv
package sdsh_pkg;

	localparam int BLOCK_BYTES = 512;
	localparam int WAKE_BYTES = 10;
	localparam int CNT_W = 10;

	typedef enum logic [4:0] {
		PH_IDLE     = 5'd0,
		PH_WAKE     = 5'd1,
		PH_CMD0     = 5'd2,
		PH_CMD8     = 5'd3,
		PH_CMD55    = 5'd4,
		PH_ACMD41   = 5'd5,
		PH_CMD58    = 5'd6,
		PH_CMD17    = 5'd7,
		PH_CMD24    = 5'd8,
		PH_CMD32    = 5'd9,
		PH_CMD33    = 5'd10,
		PH_CMD38    = 5'd11,
		PH_CMD13    = 5'd12,
		PH_R7TAIL   = 5'd13,
		PH_R7DUMMY  = 5'd14,
		PH_OCRTAIL  = 5'd15,
		PH_OCRDUMMY = 5'd16,
		PH_TOKEN    = 5'd17,
		PH_RDATA    = 5'd18,
		PH_RTAIL    = 5'd19,
		PH_WSTART   = 5'd20,
		PH_WDATA    = 5'd21,
		PH_WCRC     = 5'd22,
		PH_WRESP    = 5'd23,
		PH_WDUMMY   = 5'd24
	} phase_t;

	typedef enum logic [2:0] {
		CMD_BYTE   = 3'd0,
		CMD_INIT   = 3'd1,
		CMD_READ   = 3'd2,
		CMD_WRITE  = 3'd3,
		CMD_ERASE  = 3'd4,
		CMD_STATUS = 3'd5
	} cmd_t;

	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_NO_IDLE = 3'd1;
	localparam logic [2:0] ST_UNKNOWN = 3'd2;
	localparam logic [2:0] ST_REJECT = 3'd3;
	localparam logic [2:0] ST_WREJECT = 3'd4;

	localparam logic [0:0] REG_RETRY = 1'b0;
	localparam logic [0:0] REG_POLL = 1'b1;

	// classified item passed from front to back
	typedef struct packed {
		logic [2:0]  command;
		logic [31:0] sector;
		logic [7:0]  miso_byte;
		logic [7:0]  write_byte;
	} item_t;

	typedef struct packed {
		logic [7:0] mosi_byte;
		logic       exchange_wanted;
		logic       chip_select_n;
		logic       slow_clock;
		logic [7:0] read_data;
		logic       read_valid;
		logic       done_res;
		logic [2:0] status;
	} result_t;

	function automatic logic [7:0] cmd_idx(input phase_t p);
		case (p)
			PH_CMD0:   cmd_idx = 8'd0;
			PH_CMD8:   cmd_idx = 8'd8;
			PH_CMD55:  cmd_idx = 8'd55;
			PH_ACMD41: cmd_idx = 8'd41;
			PH_CMD58:  cmd_idx = 8'd58;
			PH_CMD17:  cmd_idx = 8'd17;
			PH_CMD24:  cmd_idx = 8'd24;
			PH_CMD32:  cmd_idx = 8'd32;
			PH_CMD33:  cmd_idx = 8'd33;
			PH_CMD38:  cmd_idx = 8'd38;
			PH_CMD13:  cmd_idx = 8'd13;
			default:   cmd_idx = 8'd0;
		endcase
	endfunction

endpackage

### hdl/sdsh_front.sv
module sdsh_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [2:0]         command,
	input  logic [31:0]        sector,
	input  logic [7:0]         miso_byte,
	input  logic [7:0]         write_byte,
	output logic               q_valid,
	input  logic               q_pop,
	output sdsh_pkg::item_t    q_item
);

	// two-entry queue
	sdsh_pkg::item_t mem_q [2];
	logic rd_ptr_q, wr_ptr_q;
	logic [1:0] count_q;
	logic push;

	assign in_stall = (count_q == 2'd2);
	assign push = in_valid && !in_stall;
	assign q_valid = (count_q != 2'd0);
	assign q_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= '{command, sector, miso_byte, write_byte};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= 1'b0;
			wr_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (q_pop) rd_ptr_q <= !rd_ptr_q;
			count_q <= count_q + {1'b0, push} - {1'b0, q_pop};
		end
	end

endmodule

### hdl/sdsh_back.sv
module sdsh_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [0:0]         cfg_index,
	input  logic [7:0]         cfg_data,
	input  logic               q_valid,
	output logic               q_pop,
	input  sdsh_pkg::item_t    q_item,
	output logic               out_valid,
	input  logic               out_stall,
	output sdsh_pkg::result_t  res_q
);

	logic [7:0] retry_lim_q;
	logic [3:0] poll_lim_q;
	sdsh_pkg::phase_t phase_q, ph;
	logic [9:0] bc_q, bc;
	logic [3:0] pc_q, pc;
	logic [7:0] rc_q, rc;
	logic [1:0] kind_q, kind;
	logic [31:0] arg_q, arg, cap_q, cap;
	logic seen_q, seen;
	logic out_valid_q;
	sdsh_pkg::result_t res;
	logic step;
	logic [7:0] r, mosi, fidx, rd;
	logic [3:0] pc_inc;
	logic pdone, byte_addr, done, rv;
	logic [2:0] st;

	assign out_valid = out_valid_q;
	assign step = q_valid && (!out_valid_q || !out_stall);
	assign q_pop = step;
	assign r = q_item.miso_byte;
	assign byte_addr = (kind_q == 2'd1) || (kind_q == 2'd2);
	assign pc_inc = pc_q + 4'd1;
	assign pdone = pc_inc >= poll_lim_q;
	assign fidx = sdsh_pkg::cmd_idx(phase_q);

	always_comb begin
		ph = phase_q; bc = bc_q; pc = pc_q; rc = rc_q; kind = kind_q;
		arg = arg_q; cap = cap_q; seen = seen_q;
		mosi = 8'hFF; done = 1'b0; st = sdsh_pkg::ST_OK;
		rd = 8'd0; rv = 1'b0;
		if (phase_q == sdsh_pkg::PH_IDLE) begin
			case (q_item.command)
				sdsh_pkg::CMD_INIT: begin
					kind = 2'd0; ph = sdsh_pkg::PH_WAKE; bc = '0;
				end
				sdsh_pkg::CMD_READ, sdsh_pkg::CMD_WRITE, sdsh_pkg::CMD_ERASE: begin
					ph = (q_item.command == sdsh_pkg::CMD_READ) ? sdsh_pkg::PH_CMD17 :
						(q_item.command == sdsh_pkg::CMD_WRITE) ? sdsh_pkg::PH_CMD24 :
						sdsh_pkg::PH_CMD32;
					arg = byte_addr ? {q_item.sector[22:0], 9'd0} : q_item.sector;
					bc = '0; pc = '0; seen = 1'b0;
				end
				sdsh_pkg::CMD_STATUS: begin
					ph = sdsh_pkg::PH_CMD13; arg = '0; bc = '0; pc = '0; seen = 1'b0;
				end
				default: ;
			endcase
		end else if (phase_q inside {[sdsh_pkg::PH_CMD0 : sdsh_pkg::PH_CMD13]}
				&& bc_q < 10'd7) begin
			if (bc_q < 10'd6) begin
				bc = bc_q + 10'd1;
				case (bc)
					10'd1: mosi = fidx | 8'h40;
					10'd2: mosi = arg_q[31:24];
					10'd3: mosi = arg_q[23:16];
					10'd4: mosi = arg_q[15:8];
					10'd5: mosi = arg_q[7:0];
					10'd6: mosi = (fidx == 8'd0) ? 8'h95 : ((fidx == 8'd8) ? 8'h87 : 8'hFF);
					default: mosi = 8'hFF;
				endcase
			end else begin
				bc = 10'd7; pc = '0;
			end
		end else begin
			case (phase_q)
				sdsh_pkg::PH_WAKE: begin
					bc = bc_q + 10'd1;
					if (bc >= 10'(sdsh_pkg::WAKE_BYTES)) begin
						ph = sdsh_pkg::PH_CMD0; arg = '0; bc = '0; pc = '0; seen = 1'b0;
					end
				end
				sdsh_pkg::PH_CMD0: begin
					if (r == 8'h01) seen = 1'b1;
					pc = pc_inc;
					if (pdone) begin
						if (seen) begin
							ph = sdsh_pkg::PH_CMD8; arg = 32'h000001AA;
							bc = '0; pc = '0; seen = 1'b0;
						end else begin
							kind = 2'd0; ph = sdsh_pkg::PH_IDLE; done = 1'b1;
							st = sdsh_pkg::ST_NO_IDLE;
						end
					end
				end
				sdsh_pkg::PH_CMD8: begin
					if (r == 8'h05) begin
						kind = 2'd1; ph = sdsh_pkg::PH_R7DUMMY;
					end else if (r == 8'h01) begin
						pc = pc_inc; ph = sdsh_pkg::PH_R7TAIL; bc = '0; cap = '0;
					end else begin
						pc = pc_inc;
						if (pdone) ph = sdsh_pkg::PH_R7DUMMY;
					end
				end
				sdsh_pkg::PH_R7TAIL: begin
					cap = {cap_q[23:0], r};
					bc = bc_q + 10'd1;
					if (bc >= 10'd4) begin
						if (cap[15:0] == 16'h01AA) begin
							kind = 2'd2; ph = sdsh_pkg::PH_R7DUMMY;
						end else if (pc_q >= poll_lim_q) begin
							ph = sdsh_pkg::PH_R7DUMMY;
						end else begin
							ph = sdsh_pkg::PH_CMD8; bc = 10'd7;
						end
					end
				end
				sdsh_pkg::PH_R7DUMMY: begin
					if (kind_q == 2'd0) begin
						ph = sdsh_pkg::PH_IDLE; done = 1'b1; st = sdsh_pkg::ST_UNKNOWN;
					end else begin
						rc = '0; ph = sdsh_pkg::PH_CMD55; arg = '0;
						bc = '0; pc = '0; seen = 1'b0;
					end
				end
				sdsh_pkg::PH_CMD55: begin
					pc = pc_inc;
					if (pdone) begin
						ph = sdsh_pkg::PH_ACMD41; arg = 32'h40000000;
						bc = '0; pc = '0; seen = 1'b0;
					end
				end
				sdsh_pkg::PH_ACMD41: begin
					if (r == 8'h00) seen = 1'b1;
					pc = pc_inc;
					if (pdone) begin
						rc = rc_q + 8'd1;
						if (seen) begin
							if (kind_q == 2'd2) begin
								cap = '0; ph = sdsh_pkg::PH_CMD58; arg = '0;
								bc = '0; pc = '0; seen = 1'b0;
							end else begin
								ph = sdsh_pkg::PH_IDLE; done = 1'b1;
							end
						end else if (rc >= retry_lim_q) begin
							kind = 2'd0; ph = sdsh_pkg::PH_IDLE; done = 1'b1;
							st = sdsh_pkg::ST_REJECT;
						end else begin
							ph = sdsh_pkg::PH_CMD55; arg = '0; bc = '0; pc = '0; seen = 1'b0;
						end
					end
				end
				sdsh_pkg::PH_CMD58: begin
					if (r == 8'h00) begin
						ph = sdsh_pkg::PH_OCRTAIL; bc = '0; cap = '0;
					end else begin
						pc = pc_inc;
						if (pdone) begin
							cap = '0; ph = sdsh_pkg::PH_OCRDUMMY;
						end
					end
				end
				sdsh_pkg::PH_OCRTAIL: begin
					cap = {cap_q[23:0], r};
					bc = bc_q + 10'd1;
					if (bc >= 10'd4) ph = sdsh_pkg::PH_OCRDUMMY;
				end
				sdsh_pkg::PH_OCRDUMMY: begin
					kind = (cap_q[31:30] == 2'b11) ? 2'd3 : 2'd2;
					ph = sdsh_pkg::PH_IDLE; done = 1'b1;
				end
				sdsh_pkg::PH_CMD17, sdsh_pkg::PH_TOKEN, sdsh_pkg::PH_CMD24,
				sdsh_pkg::PH_CMD32, sdsh_pkg::PH_CMD33, sdsh_pkg::PH_CMD38,
				sdsh_pkg::PH_CMD13: begin
					if (r == ((phase_q == sdsh_pkg::PH_TOKEN) ? 8'hFE : 8'h00)) begin
						case (phase_q)
							sdsh_pkg::PH_CMD17: begin ph = sdsh_pkg::PH_TOKEN; pc = '0; end
							sdsh_pkg::PH_TOKEN: begin ph = sdsh_pkg::PH_RDATA; bc = '0; end
							sdsh_pkg::PH_CMD24: begin ph = sdsh_pkg::PH_WSTART; mosi = 8'hFE; end
							sdsh_pkg::PH_CMD32: begin
								ph = sdsh_pkg::PH_CMD33;
								arg = arg_q + (byte_addr ? 32'd512 : 32'd1);
								bc = '0; pc = '0; seen = 1'b0;
							end
							sdsh_pkg::PH_CMD33: begin
								ph = sdsh_pkg::PH_CMD38; arg = '0; bc = '0; pc = '0; seen = 1'b0;
							end
							default: begin ph = sdsh_pkg::PH_IDLE; done = 1'b1; end
						endcase
					end else begin
						pc = pc_inc;
						if (pdone) begin
							ph = sdsh_pkg::PH_IDLE; done = 1'b1; st = sdsh_pkg::ST_REJECT;
						end
					end
				end
				sdsh_pkg::PH_RDATA: begin
					rd = r; rv = 1'b1;
					if (bc_q >= 10'(sdsh_pkg::BLOCK_BYTES - 1)) begin
						ph = sdsh_pkg::PH_RTAIL; bc = '0;
					end else bc = bc_q + 10'd1;
				end
				sdsh_pkg::PH_RTAIL: begin
					bc = bc_q + 10'd1;
					if (bc >= 10'd3) begin ph = sdsh_pkg::PH_IDLE; done = 1'b1; end
				end
				sdsh_pkg::PH_WSTART: begin
					ph = sdsh_pkg::PH_WDATA; bc = '0; mosi = q_item.write_byte;
				end
				sdsh_pkg::PH_WDATA: begin
					if (bc_q >= 10'(sdsh_pkg::BLOCK_BYTES - 1)) begin
						ph = sdsh_pkg::PH_WCRC; bc = '0;
					end else begin
						bc = bc_q + 10'd1; mosi = q_item.write_byte;
					end
				end
				sdsh_pkg::PH_WCRC: begin
					bc = bc_q + 10'd1;
					if (bc >= 10'd2) ph = sdsh_pkg::PH_WRESP;
				end
				sdsh_pkg::PH_WRESP: begin
					seen = (r[4:0] == 5'h05);
					ph = sdsh_pkg::PH_WDUMMY;
				end
				sdsh_pkg::PH_WDUMMY: begin
					ph = sdsh_pkg::PH_IDLE; done = 1'b1;
					st = seen_q ? sdsh_pkg::ST_OK : sdsh_pkg::ST_WREJECT;
				end
				default: begin
					ph = sdsh_pkg::PH_IDLE; done = 1'b1; st = sdsh_pkg::ST_REJECT;
				end
			endcase
		end
	end

	always_comb begin
		res = '0;
		res.exchange_wanted = (ph != sdsh_pkg::PH_IDLE);
		res.mosi_byte = res.exchange_wanted ? mosi : 8'hFF;
		res.chip_select_n = (ph == sdsh_pkg::PH_IDLE) || (ph == sdsh_pkg::PH_WAKE);
		res.slow_clock = (ph == sdsh_pkg::PH_WAKE) || (ph == sdsh_pkg::PH_CMD0) ||
			((ph == sdsh_pkg::PH_IDLE) && (kind == 2'd0));
		res.read_data = rd;
		res.read_valid = rv;
		res.done_res = done;
		res.status = st;
	end

	always_ff @(posedge clk) begin
		if (step) res_q <= res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			retry_lim_q <= 8'd100;
			poll_lim_q <= 4'd5;
			phase_q <= sdsh_pkg::PH_IDLE;
			bc_q <= '0; pc_q <= '0; rc_q <= '0; kind_q <= '0;
			arg_q <= '0; cap_q <= '0; seen_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == sdsh_pkg::REG_RETRY) retry_lim_q <= cfg_data;
				else poll_lim_q <= cfg_data[3:0];
			end
			if (step) begin
				phase_q <= ph; bc_q <= bc; pc_q <= pc; rc_q <= rc; kind_q <= kind;
				arg_q <= arg; cap_q <= cap; seen_q <= seen;
			end
			if (step) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

endmodule

### hdl/sd_card_spi_host_sequencer.sv
// channel  | handshake           | payload
// in       | in_valid, in_stall  | command, sector, miso_byte, write_byte
// out      | out_valid, out_stall| mosi_byte .. status
// cfg      | cfg_we              | cfg_index, cfg_data
// one result per transaction; a transaction passes a two-entry queue and then
// the sequencer step; one item per cycle sustained while out_stall is low.
// an accepted input is registered in the queue, then in the result register.
// reset clears the queue, the sequencer state and loads the register defaults.
// out_stall holds the result register and backs the queue up to in_stall.
module sd_card_spi_host_sequencer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  command,
	input  logic [31:0] sector,
	input  logic [7:0]  miso_byte,
	input  logic [7:0]  write_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  mosi_byte,
	output logic        exchange_wanted,
	output logic        chip_select_n,
	output logic        slow_clock,
	output logic [7:0]  read_data,
	output logic        read_valid,
	output logic        done_res,
	output logic [2:0]  status
);

	logic q_valid, q_pop;
	sdsh_pkg::item_t q_item;
	sdsh_pkg::result_t res;

	sdsh_front u_front (
		.clk, .arst_n, .in_valid, .in_stall, .command, .sector, .miso_byte,
		.write_byte, .q_valid, .q_pop, .q_item
	);

	sdsh_back u_back (
		.clk, .arst_n, .cfg_we, .cfg_index, .cfg_data, .q_valid, .q_pop, .q_item,
		.out_valid, .out_stall, .res_q(res)
	);

	assign mosi_byte = res.mosi_byte;
	assign exchange_wanted = res.exchange_wanted;
	assign chip_select_n = res.chip_select_n;
	assign slow_clock = res.slow_clock;
	assign read_data = res.read_data;
	assign read_valid = res.read_valid;
	assign done_res = res.done_res;
	assign status = res.status;

endmodule

### hdl/sdsh_checker.sv
module sdsh_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] mosi_byte,
	input logic       exchange_wanted,
	input logic       chip_select_n,
	input logic [7:0] read_data,
	input logic       read_valid,
	input logic       done_res,
	input logic [2:0] status
);

	a_idle_mosi: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !exchange_wanted |-> mosi_byte == 8'hFF && chip_select_n)
		else $error("idle result drives mosi");
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !done_res |-> status == 3'd0)
		else $error("status without done");
	a_read: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !read_valid |-> read_data == 8'd0)
		else $error("read data without valid");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(mosi_byte))
		else $error("stalled result changed");

endmodule

bind sd_card_spi_host_sequencer sdsh_checker u_sdsh_checker (.*);
